### rtl/rmt_pkg.sv
// Shared types and constants for the running median tracker.
package rmt_pkg;

  localparam int unsigned ValueW      = 31;
  localparam int unsigned CountW      = 11;
  localparam int unsigned CapacityDef = 1024;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              start_new;
  } in_word_t;

  typedef struct packed {
    logic [ValueW-1:0] median;
    logic [CountW-1:0] count_so_far;
    logic              store_full;
  } out_word_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic              en;
    logic [ValueW-1:0] value;
  } ins_t;

endpackage

### rtl/rmt_cell.sv
// One compare-and-shift cell of the sorted insertion chain.
module rmt_cell (
  input  logic                        clk_i,
  input  rmt_pkg::ins_t               ins_i,
  input  logic                        occ_i,
  input  logic [rmt_pkg::ValueW-1:0]  left_value_i,
  input  logic                        left_gt_i,
  output logic [rmt_pkg::ValueW-1:0]  value_o,
  output logic                        gt_o
);

  logic [rmt_pkg::ValueW-1:0] value_q;
  logic [rmt_pkg::ValueW-1:0] value_d;

  assign gt_o    = occ_i & (value_q > ins_i.value);
  assign value_o = value_q;

  always_comb begin
    if (left_gt_i) begin
      value_d = left_value_i;
    end else if (gt_o || !occ_i) begin
      value_d = ins_i.value;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i.en) begin
      value_q <= value_d;
    end
  end

endmodule

### rtl/running_median_tracker_unit.sv
// Top level of the running median tracker: insertion chain, count and result stage.
//
// One word is taken in every clock cycle; busy stays low. A word is inserted
// into a chain of CAPACITY compare-and-shift cells in the cycle it is taken, and its
// result, if any, passes pend_q or full_q and then result_valid_q, and appears on
// result_o with result_valid_o for one cycle. The median tap is picked from the
// chain by the updated count in the result stage. A word with start_new set
// empties the store first. A word that finds the store full is dropped and
// yields a result with store_full set and median zero. The receiver cannot stall.
module running_median_tracker_unit #(
  parameter int unsigned CAPACITY = rmt_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rmt_pkg::in_word_t  in_word_i,
  output logic               result_valid_o,
  output rmt_pkg::out_word_t result_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic [CntW-1:0] count_q, count_d, count_eff;
  logic            accept, full;
  logic            pend_q, full_q;
  logic [IdxW-1:0] med_idx;

  rmt_pkg::ins_t              ins;
  logic [rmt_pkg::ValueW-1:0] cell_val [CAPACITY];
  logic                       cell_gt  [CAPACITY];
  logic                       cell_occ [CAPACITY];

  rmt_pkg::out_word_t result_q;
  logic               result_valid_q;

  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign count_eff = in_word_i.start_new ? '0 : count_q;
  assign full      = count_eff >= CntW'(CAPACITY);

  assign ins.en    = accept & ~full;
  assign ins.value = in_word_i.value;

  assign count_d = ins.en ? count_eff + CntW'(1) : count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = CntW'(i) < count_eff;
    if (i == 0) begin : g_first
      rmt_cell u_cell (
        .clk_i        (clk_i),
        .ins_i        (ins),
        .occ_i        (cell_occ[i]),
        .left_value_i ('0),
        .left_gt_i    (1'b0),
        .value_o      (cell_val[i]),
        .gt_o         (cell_gt[i])
      );
    end else begin : g_rest
      rmt_cell u_cell (
        .clk_i        (clk_i),
        .ins_i        (ins),
        .occ_i        (cell_occ[i]),
        .left_value_i (cell_val[i-1]),
        .left_gt_i    (cell_gt[i-1]),
        .value_o      (cell_val[i]),
        .gt_o         (cell_gt[i])
      );
    end
  end

  assign med_idx = IdxW'(count_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      pend_q         <= 1'b0;
      full_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      pend_q         <= ins.en & ~count_eff[0];
      full_q         <= accept & full;
      result_valid_q <= pend_q | full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.median       <= full_q ? '0 : cell_val[med_idx];
    result_q.count_so_far <= rmt_pkg::CountW'(count_q);
    result_q.store_full   <= full_q;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("count beyond capacity");

  a_odd_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.store_full |-> result_o.count_so_far[0])
    else $error("median word with even count");

  a_full_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.store_full |-> result_o.median == '0)
    else $error("full word carries a median");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.start_new |=> count_q == CntW'(1))
    else $error("restart did not leave one entry");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full |=> count_q == $past(count_q))
    else $error("dropped word changed the count");

endmodule
